// ===== sv/hds_pkg.sv =====
package hds_pkg;

   localparam int HEIGHT_W  = 16;
   localparam int COORD_W   = 7;
   localparam int COLOR_W   = 32;
   localparam int FACTOR_W  = 17;
   localparam int SPACING_W = 10;
   localparam int LIGHT_W   = 16;
   localparam int CSR_DATA_W = 16;

   localparam int GRID_SIDE_DEF = 128;

   localparam logic [SPACING_W-1:0]      SPACING_RST = 10'd10;
   localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd0;
   localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd16384;
   localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd0;

   typedef enum logic [1:0] {
      CSR_SPACING = 2'd0,
      CSR_LIGHT_X = 2'd1,
      CSR_LIGHT_Y = 2'd2,
      CSR_LIGHT_Z = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_STORE = 1'b0,
      ACT_SHADE = 1'b1
   } action_type;

endpackage

// ===== sv/heightmap_diffuse_shader_top.sv =====
// throughput: one item per cycle while rsp_tready does not stall the output; the
// pipeline of the 34-step divider and the 17-step square root takes a new item
// every unstalled cycle, the three height reads come from two copies of the height
// memory (two read ports plus one)
// reset: synchronous, clears pipeline valids and loads the register defaults;
// the height memory is not cleared and holds nothing until written
module heightmap_diffuse_shader_top #(
   parameter int GRID_SIDE = hds_pkg::GRID_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // grid_row[6:0], grid_col[13:7], height_value[29:14], texel_color[61:30], zero pad
   input  logic [63:0] req_tdata,
   // action[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // shaded_color[31:0], shade_factor[48:32], zero pad
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [hds_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW        = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
   localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
   localparam int AW        = $clog2(DEPTH);
   localparam int DIV_STEPS = 34;
   localparam int SQRT_STEPS = 17;

   // configuration
   logic [hds_pkg::SPACING_W-1:0]      cfg_spacing_ff;
   logic signed [hds_pkg::LIGHT_W-1:0] cfg_light_x_ff;
   logic signed [hds_pkg::LIGHT_W-1:0] cfg_light_y_ff;
   logic signed [hds_pkg::LIGHT_W-1:0] cfg_light_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_spacing_ff <= hds_pkg::SPACING_RST;
         cfg_light_x_ff <= hds_pkg::LIGHT_X_RST;
         cfg_light_y_ff <= hds_pkg::LIGHT_Y_RST;
         cfg_light_z_ff <= hds_pkg::LIGHT_Z_RST;
      end else if (csr_valid) begin
         case (csr_index)
            hds_pkg::CSR_SPACING: cfg_spacing_ff <= csr_wdata[hds_pkg::SPACING_W-1:0];
            hds_pkg::CSR_LIGHT_X: cfg_light_x_ff <= $signed(csr_wdata);
            hds_pkg::CSR_LIGHT_Y: cfg_light_y_ff <= $signed(csr_wdata);
            hds_pkg::CSR_LIGHT_Z: cfg_light_z_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // input fields
   logic [hds_pkg::COORD_W-1:0]  in_row;
   logic [hds_pkg::COORD_W-1:0]  in_col;
   logic [hds_pkg::HEIGHT_W-1:0] in_height;
   logic [hds_pkg::COLOR_W-1:0]  in_texel;

   assign in_row    = req_tdata[6:0];
   assign in_col    = req_tdata[13:7];
   assign in_height = req_tdata[29:14];
   assign in_texel  = req_tdata[61:30];

   logic advance;
   logic out_en;
   logic m_v_ff;
   logic rsp_tvalid_ff;
   logic accept;
   logic row_in_grid;
   logic col_in_grid;
   logic wr_en;
   logic shade_in;

   // the output register loads when it is free or being drained; the rest of
   // the pipeline also moves when the stage in front of it is empty
   assign out_en     = !rsp_tvalid_ff || rsp_tready;
   assign advance    = out_en || !m_v_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign row_in_grid = 32'(in_row) < 32'(GRID_SIDE);
   assign col_in_grid = 32'(in_col) < 32'(GRID_SIDE);
   assign wr_en    = accept && (req_tuser == hds_pkg::ACT_STORE) && row_in_grid && col_in_grid;
   assign shade_in = accept && (req_tuser == hds_pkg::ACT_SHADE);

   logic [IW-1:0] r_idx, c_idx, r1_idx, c1_idx;
   logic [AW-1:0] addr_a, addr_b, addr_c;

   always_comb begin
      r_idx  = row_in_grid ? IW'(in_row) : IW'(GRID_SIDE - 1);
      c_idx  = col_in_grid ? IW'(in_col) : IW'(GRID_SIDE - 1);
      r1_idx = (r_idx == IW'(GRID_SIDE - 1)) ? r_idx : r_idx + IW'(1);
      c1_idx = (c_idx == IW'(GRID_SIDE - 1)) ? c_idx : c_idx + IW'(1);
      addr_a = AW'(r_idx) * AW'(GRID_SIDE) + AW'(c_idx);
      addr_b = AW'(r_idx) * AW'(GRID_SIDE) + AW'(c1_idx);
      addr_c = AW'(r1_idx) * AW'(GRID_SIDE) + AW'(c_idx);
   end

   // two copies of the height store: copy 0 serves own and right, copy 1 lower
   logic [hds_pkg::HEIGHT_W-1:0] mem0_ff [DEPTH];
   logic [hds_pkg::HEIGHT_W-1:0] mem1_ff [DEPTH];
   logic [hds_pkg::HEIGHT_W-1:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic [AW-1:0]                wr_addr;

   assign wr_addr = AW'(r_idx) * AW'(GRID_SIDE) + AW'(c_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0_ff[wr_addr] <= in_height;
      end
      if (advance) begin
         rd_a_ff <= mem0_ff[addr_a];
         rd_b_ff <= mem0_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem1_ff[wr_addr] <= in_height;
      end
      if (advance) begin
         rd_c_ff <= mem1_ff[addr_c];
      end
   end

   // front stages: differences, products, dot and squared length, n squared
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [hds_pkg::COLOR_W-1:0] s1_tex_ff, s2_tex_ff, s3_tex_ff, s4_tex_ff, s5_tex_ff;
   logic signed [16:0] s2_db_ff, s2_dc_ff;
   logic signed [32:0] s3_px_ff, s3_pz_ff;
   logic signed [26:0] s3_py_ff;
   logic [31:0] s3_qb_ff, s3_qc_ff;
   logic [19:0] s3_ss_ff;
   logic [32:0] s4_n_ff;
   logic [33:0] s4_l2_ff;
   logic        s4_zero_ff;
   logic [65:0] s5_nsq_ff;
   logic [33:0] s5_l2_ff;
   logic        s5_zero_ff;

   logic signed [16:0] db_in, dc_in;
   logic signed [32:0] px_in, pz_in;
   logic signed [26:0] py_in;
   logic signed [33:0] qb_in, qc_in;
   logic [19:0] ss_in;
   logic signed [35:0] n_in;
   logic [33:0] l2_in;
   logic [65:0] nsq_in;

   always_comb begin
      db_in  = $signed({1'b0, rd_b_ff}) - $signed({1'b0, rd_a_ff});
      dc_in  = $signed({1'b0, rd_c_ff}) - $signed({1'b0, rd_a_ff});
      px_in  = s2_db_ff * cfg_light_x_ff;
      pz_in  = s2_dc_ff * cfg_light_z_ff;
      py_in  = $signed({1'b0, cfg_spacing_ff}) * cfg_light_y_ff;
      qb_in  = s2_db_ff * s2_db_ff;
      qc_in  = s2_dc_ff * s2_dc_ff;
      ss_in  = 20'(cfg_spacing_ff) * 20'(cfg_spacing_ff);
      n_in   = 36'(s3_pz_ff) - 36'(s3_px_ff) + 36'(s3_py_ff);
      l2_in  = 34'(s3_qb_ff) + 34'(s3_qc_ff) + 34'(s3_ss_ff);
      nsq_in = 66'(s4_n_ff) * 66'(s4_n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= shade_in;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tex_ff  <= in_texel;
         s2_tex_ff  <= s1_tex_ff;
         s2_db_ff   <= db_in;
         s2_dc_ff   <= dc_in;
         s3_tex_ff  <= s2_tex_ff;
         s3_px_ff   <= px_in;
         s3_py_ff   <= py_in;
         s3_pz_ff   <= pz_in;
         s3_qb_ff   <= qb_in[31:0];
         s3_qc_ff   <= qc_in[31:0];
         s3_ss_ff   <= ss_in;
         s4_tex_ff  <= s3_tex_ff;
         s4_n_ff    <= n_in[32:0];
         s4_l2_ff   <= l2_in;
         s4_zero_ff <= n_in[35] || (n_in == '0) || (l2_in == '0);
         s5_tex_ff  <= s4_tex_ff;
         s5_nsq_ff  <= nsq_in;
         s5_l2_ff   <= s4_l2_ff;
         s5_zero_ff <= s4_zero_ff;
      end
   end

   // restoring divider: q = floor(64 n^2 / l2), saturated to 34 bits
   logic        dv_v_ff    [DIV_STEPS+1];
   logic [31:0] dv_tex_ff  [DIV_STEPS+1];
   logic [33:0] dv_rem_ff  [DIV_STEPS+1];
   logic [33:0] dv_low_ff  [DIV_STEPS+1];
   logic [33:0] dv_q_ff    [DIV_STEPS+1];
   logic [33:0] dv_l2_ff   [DIV_STEPS+1];
   logic        dv_sat_ff  [DIV_STEPS+1];
   logic        dv_zero_ff [DIV_STEPS+1];

   logic [33:0] dv_rem_in [DIV_STEPS+1];
   logic [33:0] dv_q_in   [DIV_STEPS+1];
   logic [37:0] dv_upper;
   logic [34:0] dv_sh;
   logic [34:0] dv_diff;

   always_comb begin
      dv_upper     = s5_nsq_ff[65:28];
      dv_rem_in[0] = dv_upper[33:0];
      dv_q_in[0]   = '0;
      dv_sh        = '0;
      dv_diff      = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dv_sh   = {dv_rem_ff[k-1], dv_low_ff[k-1][33]};
         dv_diff = dv_sh - {1'b0, dv_l2_ff[k-1]};
         if (dv_sh >= {1'b0, dv_l2_ff[k-1]}) begin
            dv_rem_in[k] = dv_diff[33:0];
            dv_q_in[k]   = {dv_q_ff[k-1][32:0], 1'b1};
         end else begin
            dv_rem_in[k] = dv_sh[33:0];
            dv_q_in[k]   = {dv_q_ff[k-1][32:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dv_v_ff[0] <= s5_v_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_tex_ff[0]  <= s5_tex_ff;
         dv_rem_ff[0]  <= dv_rem_in[0];
         dv_low_ff[0]  <= {s5_nsq_ff[27:0], 6'b0};
         dv_q_ff[0]    <= dv_q_in[0];
         dv_l2_ff[0]   <= s5_l2_ff;
         dv_sat_ff[0]  <= dv_upper >= {4'b0, s5_l2_ff};
         dv_zero_ff[0] <= s5_zero_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_tex_ff[k]  <= dv_tex_ff[k-1];
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_low_ff[k]  <= {dv_low_ff[k-1][32:0], 1'b0};
            dv_q_ff[k]    <= dv_q_in[k];
            dv_l2_ff[k]   <= dv_l2_ff[k-1];
            dv_sat_ff[k]  <= dv_sat_ff[k-1];
            dv_zero_ff[k] <= dv_zero_ff[k-1];
         end
      end
   end

   // digit-by-digit square root, two radicand bits a step
   logic        sq_v_ff    [SQRT_STEPS+1];
   logic [31:0] sq_tex_ff  [SQRT_STEPS+1];
   logic [33:0] sq_rad_ff  [SQRT_STEPS+1];
   logic [19:0] sq_rem_ff  [SQRT_STEPS+1];
   logic [16:0] sq_root_ff [SQRT_STEPS+1];
   logic        sq_zero_ff [SQRT_STEPS+1];

   logic [19:0] sq_rem_in  [SQRT_STEPS+1];
   logic [16:0] sq_root_in [SQRT_STEPS+1];
   logic [21:0] sq_sh;
   logic [21:0] sq_trial;

   always_comb begin
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      sq_sh         = '0;
      sq_trial      = '0;
      for (int j = 1; j <= SQRT_STEPS; j++) begin
         sq_sh    = {sq_rem_ff[j-1], sq_rad_ff[j-1][33:32]};
         sq_trial = {3'b0, sq_root_ff[j-1], 2'b01};
         if (sq_sh >= sq_trial) begin
            sq_rem_in[j]  = 20'(sq_sh - sq_trial);
            sq_root_in[j] = {sq_root_ff[j-1][15:0], 1'b1};
         end else begin
            sq_rem_in[j]  = sq_sh[19:0];
            sq_root_in[j] = {sq_root_ff[j-1][15:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= SQRT_STEPS; j++) begin
            sq_v_ff[j] <= 1'b0;
         end
      end else if (advance) begin
         sq_v_ff[0] <= dv_v_ff[DIV_STEPS];
         for (int j = 1; j <= SQRT_STEPS; j++) begin
            sq_v_ff[j] <= sq_v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_tex_ff[0]  <= dv_tex_ff[DIV_STEPS];
         sq_rad_ff[0]  <= dv_sat_ff[DIV_STEPS] ? '1 : dv_q_ff[DIV_STEPS];
         sq_rem_ff[0]  <= sq_rem_in[0];
         sq_root_ff[0] <= sq_root_in[0];
         sq_zero_ff[0] <= dv_zero_ff[DIV_STEPS];
         for (int j = 1; j <= SQRT_STEPS; j++) begin
            sq_tex_ff[j]  <= sq_tex_ff[j-1];
            sq_rad_ff[j]  <= {sq_rad_ff[j-1][31:0], 2'b00};
            sq_rem_ff[j]  <= sq_rem_in[j];
            sq_root_ff[j] <= sq_root_in[j];
            sq_zero_ff[j] <= sq_zero_ff[j-1];
         end
      end
   end

   // largest odd t with t <= root gives the rounded cosine (t + 1) / 2
   logic [hds_pkg::FACTOR_W-1:0] m_factor_ff;
   logic [31:0]                  m_tex_ff;
   logic [17:0]                  m_sum;

   assign m_sum = 18'(sq_root_ff[SQRT_STEPS]) + 18'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (advance) begin
         m_v_ff <= sq_v_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_tex_ff    <= sq_tex_ff[SQRT_STEPS];
         m_factor_ff <= sq_zero_ff[SQRT_STEPS] ? '0 : m_sum[17:1];
      end
   end

   // output register: byte scaling with rounding
   logic [31:0] shaded_in;
   logic [25:0] lane_prod;
   logic [31:0] rsp_color_ff;
   logic [hds_pkg::FACTOR_W-1:0] rsp_factor_ff;

   always_comb begin
      shaded_in = '0;
      lane_prod = '0;
      for (int k = 0; k < 4; k++) begin
         lane_prod = 26'(m_tex_ff[8*k +: 8]) * 26'(m_factor_ff) + 26'd32768;
         shaded_in[8*k +: 8] = lane_prod[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_tvalid_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_color_ff  <= shaded_in;
         rsp_factor_ff <= m_factor_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_factor_ff, rsp_color_ff};

`ifndef SYNTHESIS
   a_dark_is_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[48:32] == 17'd0) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("zero shade factor with nonzero color");

   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[48:32] <= 17'd65536))
      else $error("shade factor above one");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (advance && m_v_ff) |=> rsp_tvalid)
      else $error("finished shade lost before the output register");
`endif

endmodule
